// ----- src/fba_pkg.sv -----
// Package for the frame bitmap allocator: sizes, operation and status codes,
// and the command/status types between controller and datapath. No dependencies.
package fba_pkg;

  localparam int MAX_FRAMES   = 4096;
  localparam int FRAME_BYTES  = 4096;
  localparam int WORD_BITS    = 32;
  localparam int NUM_WORDS    = MAX_FRAMES / WORD_BITS;
  localparam int WORD_IDX_W   = $clog2(NUM_WORDS);
  localparam int BIT_IDX_W    = $clog2(WORD_BITS);
  localparam int NWORDS_W     = WORD_IDX_W + 1;
  localparam int ADDR_W       = 32;
  localparam int PAGE_W       = $clog2(FRAME_BYTES);
  localparam int FRAME_IDX_W  = ADDR_W - PAGE_W;
  localparam int FRAME_W      = 12;
  localparam int CNT_W        = 13;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 24;

  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_FRAMES);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4096);

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_ALLOC = 2'd0;
  localparam kind_t KIND_MARK  = 2'd1;
  localparam kind_t KIND_FREE  = 2'd2;
  localparam kind_t KIND_TEST  = 2'd3;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_MAPPED  = 2'd1;
  localparam status_t ST_NO_FREE = 2'd2;
  localparam status_t ST_RANGE   = 2'd3;

  typedef struct packed {
    logic load;
    logic read;
    logic commit;
  } fba_cmd_t;

  typedef struct packed {
    logic out_free;
  } fba_sts_t;

endpackage

// ----- src/fba_ctrl.sv -----
// Controller for the frame bitmap allocator: sequences load, bitmap read and
// commit of one transaction. Depends on fba_pkg.
module fba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  fba_pkg::fba_sts_t sts,
  output fba_pkg::fba_cmd_t cmd
);
  import fba_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EXE  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EXE;
      end
      S_EXE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cmd.load   = in_tready && in_tvalid;
  assign cmd.read   = (state_r == S_RD);
  assign cmd.commit = (state_r == S_EXE) && sts.out_free;

endmodule

// ----- src/fba_datapath.sv -----
// Datapath for the frame bitmap allocator: item registers, bitmap memory,
// full-word flags, free-word search, bit update and output register. Depends on fba_pkg.
module fba_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fba_pkg::fba_cmd_t                   cmd,
  output fba_pkg::fba_sts_t                   sts,
  input  logic [fba_pkg::KIND_W-1:0]          in_tuser,
  input  logic [fba_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                cfg_we,
  input  logic [fba_pkg::CNT_W-1:0]           cfg_wdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fba_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import fba_pkg::*;

  logic [CNT_W-1:0]       frame_count_r;
  logic [CNT_W-1:0]       limit;
  logic [NWORDS_W-1:0]    nwords;

  kind_t                  kind_r;
  logic [FRAME_IDX_W-1:0] frame_r;
  logic                   cur_nz_r;
  logic                   wr_r;

  logic [WORD_BITS-1:0]   mem [NUM_WORDS];
  logic [NUM_WORDS-1:0]   row_valid_r;
  logic [NUM_WORDS-1:0]   full_r;

  logic [NUM_WORDS-1:0]   cand;
  logic [WORD_IDX_W-1:0]  enc_idx;
  logic                   enc_found;
  logic [WORD_IDX_W-1:0]  rd_word;

  logic [WORD_IDX_W-1:0]  rd_word_r;
  logic                   rd_found_r;
  logic                   rd_valid_r;
  logic [WORD_BITS-1:0]   rd_q_r;

  logic [WORD_BITS-1:0]   data_w;
  logic [BIT_IDX_W-1:0]   zb;
  logic                   zfound;
  logic [FRAME_W-1:0]     alloc_f;
  logic [BIT_IDX_W-1:0]   bit_sel;
  logic [WORD_BITS-1:0]   bit_mask;
  logic                   in_range;
  logic                   mem_we;
  logic [WORD_BITS-1:0]   mem_wd;

  status_t                res_status;
  logic [FRAME_W-1:0]     res_frame;
  logic                   res_present;
  logic                   res_we;
  logic                   res_used;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= CNT_RESET;
    end else if (cfg_we) begin
      frame_count_r <= cfg_wdata;
    end
  end

  assign limit  = (frame_count_r > MAX_CNT) ? MAX_CNT : frame_count_r;
  assign nwords = NWORDS_W'(({1'b0, limit} + (CNT_W+1)'(WORD_BITS - 1)) >> BIT_IDX_W);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_tuser;
      frame_r  <= in_tdata[PAGE_W +: FRAME_IDX_W];
      cur_nz_r <= (in_tdata[ADDR_W +: FRAME_W] != '0);
      wr_r     <= in_tdata[ADDR_W + FRAME_W];
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      cand[w] = !full_r[w] && (NWORDS_W'(w) < nwords);
    end
    enc_idx   = '0;
    enc_found = 1'b0;
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (cand[w]) begin
        enc_idx   = WORD_IDX_W'(w);
        enc_found = 1'b1;
      end
    end
  end

  assign rd_word = (kind_r == KIND_ALLOC) ? enc_idx : frame_r[BIT_IDX_W +: WORD_IDX_W];

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_word_r  <= rd_word;
      rd_found_r <= enc_found;
      rd_valid_r <= row_valid_r[rd_word];
      rd_q_r     <= mem[rd_word];
    end
    if (mem_we) begin
      mem[rd_word_r] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      full_r      <= '0;
    end else if (mem_we) begin
      row_valid_r[rd_word_r] <= 1'b1;
      full_r[rd_word_r]      <= (mem_wd == '1);
    end
  end

  assign data_w = rd_valid_r ? rd_q_r : '0;

  always_comb begin
    zb     = '0;
    zfound = 1'b0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!data_w[b]) begin
        zb     = BIT_IDX_W'(b);
        zfound = 1'b1;
      end
    end
  end

  assign alloc_f  = {rd_word_r, zb};
  assign bit_sel  = (kind_r == KIND_ALLOC) ? zb : frame_r[BIT_IDX_W-1:0];
  assign bit_mask = WORD_BITS'(1) << bit_sel;
  assign in_range = (frame_r < FRAME_IDX_W'(limit));

  always_comb begin
    mem_wd      = data_w;
    mem_we      = 1'b0;
    res_status  = ST_DONE;
    res_frame   = '0;
    res_present = 1'b0;
    res_we      = 1'b0;
    res_used    = 1'b0;
    if (kind_r == KIND_ALLOC) begin
      if (cur_nz_r) begin
        res_status = ST_MAPPED;
      end else if (!rd_found_r || !zfound || ({1'b0, alloc_f} >= limit)) begin
        res_status = ST_NO_FREE;
      end else begin
        mem_we      = cmd.commit;
        mem_wd      = data_w | bit_mask;
        res_frame   = alloc_f;
        res_present = 1'b1;
        res_we      = wr_r;
      end
    end else if (!in_range) begin
      res_status = ST_RANGE;
    end else begin
      case (kind_r)
        KIND_MARK: begin
          mem_we = cmd.commit;
          mem_wd = data_w | bit_mask;
        end
        KIND_FREE: begin
          mem_we = cmd.commit;
          mem_wd = data_w & ~bit_mask;
        end
        default: begin
          res_used = data_w[bit_sel];
        end
      endcase
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= OUT_TDATA_W'({res_used, res_we, res_present, res_frame, res_status});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- src/frame_bitmap_allocator.sv -----
// Frame bitmap allocator: one used/free bit per 4 KiB frame, 4096 frames.
// Bitmap read, then commit into the output register; commit waits while the output stalls.
// One transaction at a time, set by the single-port bitmap read-modify-write.
// Allocate searches a per-word full-flag vector with a priority encoder in the read cycle.
// Reset: synchronous active-low; bitmap reads as all free at once via per-row valid
// bits (no clearing pass), frame_count returns to 4096, output register empties.
module frame_bitmap_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fba_pkg::KIND_W-1:0]          in_tuser,   // kind
  // frame_address, current_frame, writeable
  input  logic [fba_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status, frame_number, present, write_enable, frame_used
  output logic [fba_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [fba_pkg::CNT_W-1:0]           cfg_wdata   // frame_count
);
  import fba_pkg::*;

  fba_cmd_t cmd;
  fba_sts_t sts;

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fba_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for frame_bitmap_allocator: directed and random
// allocate/mark/free/test transactions checked against a bitmap scoreboard.
// Depends on fba_pkg and the frame_bitmap_allocator RTL.
`timescale 1ns / 1ps

module tb_top;
  import fba_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SEGMENTS   = 12;
  localparam int SEG_ITEMS  = 100;

  typedef struct packed {
    logic [2:0]        pad;
    logic              writeable;
    logic [FRAME_W-1:0] current_frame;
    logic [ADDR_W-1:0] frame_address;
  } alloc_request_t;

  typedef struct packed {
    logic [6:0]         pad;
    logic               frame_used;
    logic               write_enable;
    logic               present;
    logic [FRAME_W-1:0] frame_number;
    status_t            status;
  } alloc_result_t;

  class frame_map_scoreboard;
    bit               used_frames[MAX_FRAMES];
    logic [CNT_W-1:0] frame_count = CNT_RESET;
    alloc_result_t    pending_results[$];
    int               errors = 0;

    function void set_frame_count(logic [CNT_W-1:0] value);
      frame_count = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_request(kind_t kind, alloc_request_t req);
      alloc_result_t res;
      int            limit;
      int            frame;
      int            f;
      res = '0;
      limit = (frame_count > MAX_CNT) ? MAX_FRAMES : int'(frame_count);
      frame = int'(req.frame_address >> PAGE_W);
      if (kind == KIND_ALLOC) begin
        if (req.current_frame != 0) begin
          res.status = ST_MAPPED;
        end else begin
          f = 0;
          while (f < limit && used_frames[f]) f++;
          if (f >= limit) begin
            res.status = ST_NO_FREE;
          end else begin
            used_frames[f] = 1'b1;
            res.status = ST_DONE;
            res.frame_number = FRAME_W'(f);
            res.present = 1'b1;
            res.write_enable = req.writeable;
          end
        end
      end else if (frame >= limit) begin
        res.status = ST_RANGE;
      end else begin
        case (kind)
          KIND_MARK: used_frames[frame] = 1'b1;
          KIND_FREE: used_frames[frame] = 1'b0;
          default:   res.frame_used = used_frames[frame];
        endcase
      end
      pending_results.push_back(res);
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: expected none, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      report_field("status", 32'(want.status), 32'(got.status));
      report_field("frame_number", 32'(want.frame_number), 32'(got.frame_number));
      report_field("present", 32'(want.present), 32'(got.present));
      report_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
      report_field("frame_used", 32'(want.frame_used), 32'(got.frame_used));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [KIND_W-1:0]      in_tuser   = '0;   // kind
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // frame_address, current_frame, writeable
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // status, frame_number, present, write_enable,
                                             // frame_used
  logic                   cfg_we     = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata  = '0;   // frame_count

  frame_map_scoreboard board = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;

  frame_bitmap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(alloc_result_t'(out_tdata));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("%0t: watchdog expired", $time);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  task automatic push_request(kind_t kind, logic [ADDR_W-1:0] addr,
                              logic [FRAME_W-1:0] cur, logic wr);
    alloc_request_t req;
    req = '0;
    req.frame_address = addr;
    req.current_frame = cur;
    req.writeable = wr;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= req;
    do @(posedge clk); while (!in_tready);
    board.note_request(kind, req);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_frame_count(logic [CNT_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_frame_count(value);
  endtask

  task automatic random_request(int limit);
    int                 roll;
    int                 frame;
    kind_t              kind;
    logic [ADDR_W-1:0]  addr;
    logic [FRAME_W-1:0] cur;
    roll = $urandom_range(0, 99);
    if (roll < 40) kind = KIND_ALLOC;
    else if (roll < 55) kind = KIND_MARK;
    else if (roll < 80) kind = KIND_FREE;
    else kind = KIND_TEST;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      frame = $urandom_range(0, limit + limit / 16 + 1);
      addr = {frame[FRAME_IDX_W-1:0], PAGE_W'($urandom())};
    end else if (roll < 85) begin
      frame = $urandom_range(0, 63);
      addr = {frame[FRAME_IDX_W-1:0], PAGE_W'($urandom())};
    end else begin
      addr = $urandom();
    end
    cur = ($urandom_range(0, 99) < 80) ? '0 : FRAME_W'($urandom_range(1, 4095));
    push_request(kind, addr, cur, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int               seg;
    int               n;
    int               limit;
    logic [CNT_W-1:0] plan[SEGMENTS];
    plan = '{13'd64, 13'd0, 13'd4096, 13'd33, 13'd8191, 13'd1,
             13'd4097, 13'd32, 13'd2, 13'd160, 13'd4096, 13'd0};
    plan[9] = CNT_W'($urandom_range(2, 300));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_request(KIND_ALLOC, 32'h0000_0000, 12'h000, 1'b1);
    push_request(KIND_ALLOC, 32'hFFFF_FFFF, 12'hFFF, 1'b1);
    push_request(KIND_ALLOC, 32'h0000_0000, 12'h001, 1'b0);
    push_request(KIND_MARK,  32'h0000_1000, 12'h000, 1'b0);
    push_request(KIND_TEST,  32'h0000_1FFF, 12'h000, 1'b0);
    push_request(KIND_ALLOC, 32'h0000_0000, 12'h000, 1'b0);
    push_request(KIND_FREE,  32'h0000_0FFF, 12'h000, 1'b0);
    push_request(KIND_ALLOC, 32'h0000_0000, 12'h000, 1'b1);
    push_request(KIND_TEST,  32'hFFFF_FFFF, 12'h000, 1'b0);
    push_request(KIND_MARK,  32'hFFFF_F000, 12'h000, 1'b0);
    push_request(KIND_FREE,  32'h0100_0000, 12'h000, 1'b0);
    push_request(KIND_MARK,  32'h00FF_F000, 12'h000, 1'b0);
    push_request(KIND_TEST,  32'h00FF_FFFF, 12'h000, 1'b0);
    push_request(KIND_TEST,  32'h0000_3000, 12'h000, 1'b0);
    write_frame_count(13'd0);
    push_request(KIND_ALLOC, 32'h0000_0000, 12'h000, 1'b1);
    push_request(KIND_TEST,  32'h0000_0000, 12'h000, 1'b0);
    write_frame_count(13'd8191);
    push_request(KIND_TEST,  32'h00FF_F000, 12'h000, 1'b0);
    push_request(KIND_MARK,  32'h0100_0000, 12'h000, 1'b0);
    write_frame_count(13'd1);
    push_request(KIND_ALLOC, 32'h0000_0000, 12'h000, 1'b1);
    push_request(KIND_FREE,  32'h0000_0000, 12'h000, 1'b0);
    push_request(KIND_ALLOC, 32'h0000_0000, 12'h000, 1'b1);
    push_request(KIND_ALLOC, 32'h0000_0000, 12'h000, 1'b0);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 4) begin
        tx_idle_pct = 29;
        rx_idle_pct = 71;
      end else if (seg < 8) begin
        tx_idle_pct = 71;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_frame_count(plan[seg]);
      limit = (plan[seg] > MAX_CNT) ? MAX_FRAMES : int'(plan[seg]);
      for (n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(0, 99) == 0) drain();
        random_request(limit);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- frame_bitmap_allocator.f -----
src/fba_pkg.sv
src/fba_ctrl.sv
src/fba_datapath.sv
src/frame_bitmap_allocator.sv
test/tb_top.sv
